### sv/sorted_task_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted task queue assertion macros
// Shared concurrent property shorthands for the queue's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TASK_QUEUE_DEFINES_SVH
`define SORTED_TASK_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define STQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted task queue package
// Sizes, codes and item types shared by the queue, its cells and checker.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int DEPTH  = 16;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TASK_W = 8;
   localparam int KEY_W  = 32;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      ACT_PUSH    = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_POP     = 2'd2,
      ACT_EXTRACT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE  = 1'b0,
      FSM_APPLY = 1'b1
   } fsm_type;

   typedef struct packed {
      action_type        action;
      logic [TASK_W-1:0] task_id;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [TASK_W-1:0] out_task;
      logic [KEY_W-1:0]  out_key;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TASK_W-1:0] task_id;
      logic [KEY_W-1:0]  key;
   } slot_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              load;    // latch the compare result for a new item
      logic              apply;   // commit the shift for the held item
      action_type        action;
      logic [TASK_W-1:0] task_id;
      logic [KEY_W-1:0]  key;
   } cell_ctl_type;

endpackage

### sv/sorted_task_queue.sv
// ----------------------------------------------------------------------------
// Sorted task queue
// Bounded ordered queue of (task id, key) entries held in a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  ports                         direction  carries
//   req      req_valid req_stall req_data  in         action, task id, key
//   rsp      rsp_valid rsp_stall rsp_data  out        found, entry, status, count
//
// On acceptance the item and every cell's compare flag are latched; in the
// apply step the cell row shifts and the result register loads. Requests
// are stalled while an item is applied, so one item is in work at once.
// A stalled result holds the second step back until the register is free.
// Reset empties the queue at once; slot contents need no clearing.
//
module sorted_task_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   fsm_type           state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_ctl_type      ctl;
   slot_type          slots [DEPTH];
   logic [DEPTH-1:0]  hits;
   logic [DEPTH-1:0]  prior;
   logic [DEPTH-1:0]  first;
   logic              accept;
   logic              rsp_free;
   logic              do_apply;
   logic              any_hit;
   logic              full;
   logic              is_insert;
   logic [TASK_W-1:0] sel_task;
   logic [KEY_W-1:0]  sel_key;

   assign accept   = req_valid & ~req_stall;
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign any_hit  = |hits;
   assign is_insert = (req_ff.action == ACT_PUSH) | (req_ff.action == ACT_INSERT);

   // Flags ahead of each cell: a masked reduction per cell, no ripple.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         prior[i] = |(hits & ~({DEPTH{1'b1}} << i));
      end
   end

   assign first = hits & ~prior;

   // The frontmost flagged cell is the one removed on pop or extract.
   always_comb begin
      sel_task = '0;
      sel_key  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            sel_task = sel_task | slots[i].task_id;
            sel_key  = sel_key  | slots[i].key;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:  if (accept)   state_in = FSM_APPLY;
         FSM_APPLY: if (rsp_free) state_in = FSM_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      do_apply  = 1'b0;
      unique case (state_ff)
         FSM_IDLE:  req_stall = 1'b0;
         FSM_APPLY: do_apply  = rsp_free;
      endcase
   end

   // Cells see the incoming item while loading, the held item while shifting.
   always_comb begin
      ctl.load  = accept;
      ctl.apply = do_apply & ~(is_insert & full);
      if (state_ff == FSM_IDLE) begin
         ctl.action  = req_data.action;
         ctl.task_id = req_data.task_id;
         ctl.key     = req_data.key;
      end else begin
         ctl.action  = req_ff.action;
         ctl.task_id = req_ff.task_id;
         ctl.key     = req_ff.key;
      end
   end

   // Result and entry count
   always_comb begin
      req_in       = accept ? req_data : req_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (do_apply) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         unique case (req_ff.action)
            ACT_PUSH, ACT_INSERT: begin
               if (full) rsp_in.status = STAT_FULL;
               else      count_in      = count_ff + CNT_W'(1);
            end
            ACT_POP, ACT_EXTRACT: begin
               if (any_hit) begin
                  rsp_in.found    = 1'b1;
                  rsp_in.out_task = sel_task;
                  rsp_in.out_key  = sel_key;
                  count_in        = count_ff - CNT_W'(1);
               end else if (req_ff.action == ACT_POP) begin
                  rsp_in.status = STAT_EMPTY;
               end else begin
                  rsp_in.status = STAT_NOT_FOUND;
               end
            end
         endcase
         rsp_in.occupancy = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Row of cells, front at index 0; each passes its entry to both neighbours.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type left_slot;
      slot_type right_slot;

      if (i == 0) begin : g_front
         assign left_slot = '0;
      end else begin : g_mid_l
         assign left_slot = slots[i-1];
      end

      if (i == DEPTH - 1) begin : g_back
         assign right_slot = '0;
      end else begin : g_mid_r
         assign right_slot = slots[i+1];
      end

      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prior      (prior[i]),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .hit        (hits[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/stq_cell.sv
// ----------------------------------------------------------------------------
// Sorted task queue cell
// One queue slot: holds an entry, flags itself for the item, shifts.
// ----------------------------------------------------------------------------
module stq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_pkg::cell_ctl_type ctl,
   input  logic                 prior,      // an earlier cell is flagged
   input  stq_pkg::slot_type    left_slot,  // neighbour nearer the front
   input  stq_pkg::slot_type    right_slot, // neighbour nearer the back
   output stq_pkg::slot_type    slot,
   output logic                 hit
);
   import stq_pkg::*;

   logic              valid_ff, valid_in;
   logic [TASK_W-1:0] task_ff, task_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              hit_ff, hit_in;
   logic              first;

   assign first = hit_ff & ~prior;

   always_comb begin
      hit_in = hit_ff;
      if (ctl.load) begin
         unique case (ctl.action)
            ACT_PUSH:    hit_in = 1'b1;
            ACT_INSERT:  hit_in = ~valid_ff | (key_ff >= ctl.key);
            ACT_POP:     hit_in = valid_ff;
            ACT_EXTRACT: hit_in = valid_ff & (task_ff == ctl.task_id);
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      task_in  = task_ff;
      key_in   = key_ff;
      if (ctl.apply) begin
         unique case (ctl.action)
            ACT_PUSH, ACT_INSERT: begin
               if (prior) begin
                  valid_in = left_slot.valid;
                  task_in  = left_slot.task_id;
                  key_in   = left_slot.key;
               end else if (first) begin
                  valid_in = 1'b1;
                  task_in  = ctl.task_id;
                  key_in   = ctl.key;
               end
            end
            ACT_POP, ACT_EXTRACT: begin
               if (prior | first) begin
                  valid_in = right_slot.valid;
                  task_in  = right_slot.task_id;
                  key_in   = right_slot.key;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      task_ff <= task_in;
      key_ff  <= key_in;
   end

   assign slot = '{valid: valid_ff, task_id: task_ff, key: key_ff};
   assign hit  = hit_ff;

endmodule

### sv/stq_assert.sv
// ----------------------------------------------------------------------------
// Sorted task queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_task_queue_defines.svh"

module stq_assert (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input stq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   `STQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result item changed")
   `STQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item taken while another is in work")
   `STQ_ASSERT_SAME(a_found_ok, rsp_valid && rsp_data.found, rsp_data.status == STAT_OK, "removed entry with error status")
   `STQ_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_data.found, rsp_data.out_task == '0 && rsp_data.out_key == '0, "entry fields not zero without removal")

endmodule

bind sorted_task_queue stq_assert u_stq_assert (.*);

### test/sorted_task_queue_tb.sv
// ----------------------------------------------------------------------------
// Sorted task queue testbench
// Runs directed and random queue operations against a shadow list and
// checks every returned item field by field, with random idling on both
// channels, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module sorted_task_queue_tb;

   import stq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 68;
   localparam int LONG_HOLD    = 150;
   localparam int SETTLE_WAIT  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sorted_task_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow of the queue contents, front first, updated at each accepted item.
   logic [KEY_W-1:0]  shadow_key  [DEPTH];
   logic [TASK_W-1:0] shadow_task [DEPTH];
   int                shadow_count = 0;

   req_type     pending_ops [$];        // items still to be offered
   rsp_type     expected_replies [$];   // predicted results, oldest first
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   // Driver / receiver control shared between the processes.
   bit offering      = 1'b0;   // head of pending_ops is on the req port
   bit item_taken    = 1'b0;   // set on the accept edge, cleared by the driver
   int send_gap      = 0;
   int recv_gap      = 0;
   int hold_left     = 0;
   bit long_hold_req = 1'b0;
   bit calm          = 1'b0;   // last stretch: no idling on either side

   // Applies one operation to the shadow list and returns the result item.
   function automatic rsp_type shadow_list_step(req_type op);
      rsp_type r;
      int      pos;
      int      i;
      r        = '0;
      r.status = STAT_OK;
      pos      = 0;
      case (op.action)
         ACT_PUSH, ACT_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.status = STAT_FULL;   // dropped, list untouched
            end else begin
               // sorted insert: ahead of the first key >= new key
               if (op.action == ACT_INSERT)
                  while (pos < shadow_count && shadow_key[pos] < op.key) pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_key[i]  = shadow_key[i-1];
                  shadow_task[i] = shadow_task[i-1];
               end
               shadow_key[pos]  = op.key;
               shadow_task[pos] = op.task_id;
               shadow_count++;
            end
         end
         default: begin
            // pop takes slot 0; extract takes the frontmost matching id
            if (op.action == ACT_EXTRACT)
               while (pos < shadow_count && shadow_task[pos] != op.task_id) pos++;
            if (pos >= shadow_count) begin
               if (op.action == ACT_POP) r.status = STAT_EMPTY;
               else                      r.status = STAT_NOT_FOUND;
            end else begin
               r.found    = 1'b1;
               r.out_task = shadow_task[pos];
               r.out_key  = shadow_key[pos];
               for (i = pos; i + 1 < shadow_count; i++) begin
                  shadow_key[i]  = shadow_key[i+1];
                  shadow_task[i] = shadow_task[i+1];
               end
               shadow_count--;
            end
         end
      endcase
      r.occupancy = OCC_W'(shadow_count);
      return r;
   endfunction

   function automatic void queue_op(action_type act, logic [TASK_W-1:0] id,
                                    logic [KEY_W-1:0] k);
      req_type op;
      op.action  = act;
      op.task_id = id;
      op.key     = k;
      pending_ops.push_back(op);
   endfunction

   // Random operation; fill_pct is the share of inserting actions.
   // Ids mostly come from a small pool so that extracts and duplicates hit.
   function automatic req_type random_op(int fill_pct);
      req_type op;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < fill_pct)
         op.action = ($urandom_range(0, 2) == 0) ? ACT_PUSH : ACT_INSERT;
      else
         op.action = ($urandom_range(0, 1) == 0) ? ACT_POP : ACT_EXTRACT;
      if ($urandom_range(0, 3) == 0) op.task_id = TASK_W'($urandom);
      else                           op.task_id = TASK_W'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0:       op.key = $urandom;
         1:       op.key = KEY_W'($urandom_range(0, 15));   // many equal keys
         2:       op.key = ($urandom_range(0, 1) == 0) ? '0 : '1;
         default: op.key = 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
      endcase
      return op;
   endfunction

   // Driver: presents the head of pending_ops at the falling edge and holds
   // it until accepted; random idle bursts go in between items.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (item_taken) begin
            item_taken = 1'b0;
            offering   = 1'b0;
            void'(pending_ops.pop_front());
            if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 10);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_ops.size() > 0) begin
               req_data <= pending_ops[0];
               offering  = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD - 1;
         rsp_stall    <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         recv_gap   = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predicts on each accepted request, checks each accepted result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(shadow_list_step(req_data));
            item_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("result item with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d actual %0d", want.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.out_task !== want.out_task) begin
                  $error("out_task: expected %0h actual %0h",
                         want.out_task, rsp_data.out_task);
                  fail_count++;
               end
               if (rsp_data.out_key !== want.out_key) begin
                  $error("out_key: expected %0h actual %0h",
                         want.out_key, rsp_data.out_key);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d actual %0d",
                         want.occupancy, rsp_data.occupancy);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sorted_task_queue] ERROR");
         $finish;
      end
   end

   initial begin
      int fill_mix [PHASE_COUNT] = '{80, 30, 55, 85, 20, 60, 75, 25, 50, 50};
      int phase;
      int n;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cases, fill to the brim with edge keys, then overflow.
      queue_op(ACT_POP,     8'd0,   32'd0);          // pop on empty
      queue_op(ACT_EXTRACT, 8'd3,   32'd0);          // extract on empty
      queue_op(ACT_INSERT,  8'd0,   32'd0);
      queue_op(ACT_INSERT,  8'hFF,  32'hFFFF_FFFF);
      queue_op(ACT_INSERT,  8'd1,   32'd100);
      queue_op(ACT_INSERT,  8'd2,   32'd100);        // equal key, lands first
      queue_op(ACT_INSERT,  8'd5,   32'd50);
      queue_op(ACT_INSERT,  8'd5,   32'd7);          // duplicate id
      queue_op(ACT_INSERT,  8'd3,   32'd100);
      queue_op(ACT_INSERT,  8'd4,   32'h8000_0000);
      queue_op(ACT_INSERT,  8'd6,   32'd1);
      queue_op(ACT_INSERT,  8'd7,   32'hFFFF_FFFF);
      queue_op(ACT_PUSH,    8'd8,   32'd0);
      queue_op(ACT_INSERT,  8'd9,   32'h7FFF_FFFF);
      queue_op(ACT_INSERT,  8'd10,  32'd200);
      queue_op(ACT_INSERT,  8'd11,  32'd150);
      queue_op(ACT_PUSH,    8'd12,  32'd100);
      queue_op(ACT_INSERT,  8'd13,  32'hDEAD_BEEF);  // sixteenth entry
      queue_op(ACT_PUSH,    8'd14,  32'd5);          // full
      queue_op(ACT_INSERT,  8'd15,  32'd5);          // full
      queue_op(ACT_EXTRACT, 8'd5,   32'd0);          // frontmost duplicate
      queue_op(ACT_EXTRACT, 8'd200, 32'd0);          // no match
      queue_op(ACT_POP,     8'd0,   32'd0);
      queue_op(ACT_PUSH,    8'hAA,  32'h5555_AAAA);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // sender pauses until every expected result is in
         if (phase == 0 || phase == 4 || phase == 8 || phase == PHASE_COUNT - 1)
            while (pending_ops.size() != 0 || expected_replies.size() != 0)
               @(posedge clock);
         if (phase == 3) long_hold_req = 1'b1;
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++)
            pending_ops.push_back(random_op(fill_mix[phase]));
      end

      while (pending_ops.size() != 0 || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);   // catch any stray result

      if (fail_count == 0)
         $display("[sorted_task_queue] OK");
      else
         $display("[sorted_task_queue] ERROR");
      $finish;
   end

endmodule
